>>> rtl/sird_pkg.sv
// ----------------------------------------------------------------------------
// sird_pkg: shared types and constants for the radix digit converter
// Payload structs, field widths and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package sird_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAX_DIGITS  = 32;
  localparam int unsigned BASE_WIDTH  = 5;
  localparam int unsigned CHAR_WIDTH  = 8;

  localparam int unsigned CNT_WIDTH = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_WIDTH = $clog2(MAX_DIGITS);
  localparam int unsigned BIT_WIDTH = $clog2(VALUE_WIDTH);

  localparam logic [BASE_WIDTH-1:0] BASE_MIN = BASE_WIDTH'(2);
  localparam logic [BASE_WIDTH-1:0] BASE_MAX = BASE_WIDTH'(16);

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ERROR = 8'h00;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [BASE_WIDTH-1:0]         base;
  } in_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  last;
    logic                  bad_base;
  } out_t;

  // Map a digit 0..15 to '0'-'9' or 'A'-'F'.
  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_A + CHAR_WIDTH'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> rtl/signed_integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_top: signed integer to ASCII digits
// Converts a signed value to text in base 2..16 with a bit-serial divider.
// ----------------------------------------------------------------------------
// One input transaction (value, base) yields one output transaction per
// character, most significant digit first, with a leading '-' for negative
// values and last set on the final character. A base outside 2..16 yields a
// single transaction with char_code 0, last and bad_base set. After the item
// is taken, each digit comes from the bit-serial restoring divider, which
// shifts the magnitude through one bit per cycle; the characters then go to
// the output register, one per cycle while the output is taken at once. A
// new item is taken only after the last character of the previous one has
// been loaded.
module signed_integer_to_radix_digits_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sird_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sird_pkg::out_t  out_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam int unsigned VW = sird_pkg::VALUE_WIDTH;
  localparam logic [sird_pkg::BIT_WIDTH-1:0] LastBit = sird_pkg::BIT_WIDTH'(VW - 1);
  localparam logic [sird_pkg::CNT_WIDTH-1:0] CntMax =
    sird_pkg::CNT_WIDTH'(sird_pkg::MAX_DIGITS);

  logic [1:0]                     state_q, state_d;
  logic [VW-1:0]                  mag_q, mag_d;
  logic [3:0]                     rem_q, rem_d;
  logic [sird_pkg::BASE_WIDTH-1:0] base_q, base_d;
  logic [sird_pkg::BIT_WIDTH-1:0] bit_q, bit_d;
  logic [sird_pkg::CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [sird_pkg::IDX_WIDTH-1:0] idx_q, idx_d;
  logic                           neg_q, neg_d;
  logic                           bad_q, bad_d;
  logic                           out_valid_q, out_valid_d;
  sird_pkg::out_t                 out_q, out_d;

  logic [3:0] digit_store_q [sird_pkg::MAX_DIGITS];
  logic       digit_we;

  logic                           in_acc;
  logic                           base_bad;
  logic [VW-1:0]                  v_in;
  logic [sird_pkg::BASE_WIDTH-1:0] trial;
  logic                           qbit;
  logic [3:0]                     rem_new;
  logic [sird_pkg::CNT_WIDTH-1:0] cnt_inc;
  logic                           slot_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign v_in     = in_data_i.value;
  assign base_bad = (in_data_i.base < sird_pkg::BASE_MIN) ||
                    (in_data_i.base > sird_pkg::BASE_MAX);

  // One restoring step: bring in the next magnitude bit, subtract if it fits.
  assign trial   = {rem_q, mag_q[VW-1]};
  assign qbit    = (trial >= base_q);
  assign rem_new = qbit ? 4'(trial - base_q) : trial[3:0];
  assign cnt_inc = cnt_q + sird_pkg::CNT_WIDTH'(1);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    base_d      = base_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    digit_we    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          bad_d   = base_bad;
          state_d = base_bad ? StEmit : StDiv;
          if (!base_bad) begin
            neg_d  = v_in[VW-1];
            mag_d  = v_in[VW-1] ? (~v_in + VW'(1)) : v_in;
            base_d = in_data_i.base;
            rem_d  = 4'd0;
            bit_d  = '0;
            cnt_d  = '0;
          end
        end
      end
      StDiv: begin
        rem_d = rem_new;
        mag_d = {mag_q[VW-2:0], qbit};
        bit_d = bit_q + sird_pkg::BIT_WIDTH'(1);
        if (bit_q == LastBit) begin
          // Digit done: store remainder, restart on the quotient.
          digit_we = 1'b1;
          cnt_d    = cnt_inc;
          rem_d    = 4'd0;
          bit_d    = '0;
          if (mag_d == '0 || cnt_inc == CntMax) begin
            idx_d   = cnt_q[sird_pkg::IDX_WIDTH-1:0];
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          priority if (bad_q) begin
            out_d.char_code = sird_pkg::CHAR_ERROR;
            out_d.last      = 1'b1;
            out_d.bad_base  = 1'b1;
            bad_d           = 1'b0;
            state_d         = StIdle;
          end else if (neg_q) begin
            out_d.char_code = sird_pkg::CHAR_MINUS;
            out_d.last      = 1'b0;
            out_d.bad_base  = 1'b0;
            neg_d           = 1'b0;
          end else begin
            out_d.char_code = sird_pkg::digit_char(digit_store_q[idx_q]);
            out_d.last      = (idx_q == '0);
            out_d.bad_base  = 1'b0;
            if (idx_q == '0) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - sird_pkg::IDX_WIDTH'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    base_q <= base_d;
    out_q  <= out_d;
    if (digit_we) begin
      digit_store_q[cnt_q[sird_pkg::IDX_WIDTH-1:0]] <= rem_new;
    end
  end

  // An error result is always a single, final transaction.
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_base |-> out_data_o.last &&
      out_data_o.char_code == sird_pkg::CHAR_ERROR)
    else $error("bad_base result not marked last");

  // The sign never ends a conversion.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.char_code == sird_pkg::CHAR_MINUS |-> !out_data_o.last)
    else $error("minus sign marked last");

  // Digit count stays within the store.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("digit count overflow");

  // A fresh accepted item always starts in divide or error-emit, never idle.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != StIdle)
    else $error("accepted item did not start work");

endmodule

>>> dv/tb_signed_integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// tb_signed_integer_to_radix_digits_top: radix digit converter testbench
// Drives signed values with bases from 0 to 31 and predicts the ASCII
// character stream of each conversion, including the sign, a zero value,
// the most negative value and rejected bases. Every character transaction is
// checked against the predicted text, in order; two of the random phases add
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_radix_digits_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES    = 1200;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  localparam int unsigned VW = sird_pkg::VALUE_WIDTH;
  localparam int unsigned BW = sird_pkg::BASE_WIDTH;

  // Predicts the character stream of each conversion and checks it in order.
  class digit_text_checker;
    sird_pkg::out_t expected_chars[$];
    int unsigned    mismatches = 0;

    function void note_conversion(sird_pkg::in_t item);
      logic [VW-1:0]  rest;
      logic [3:0]     digits [sird_pkg::MAX_DIGITS];
      int unsigned    count;
      sird_pkg::out_t ch;
      if (item.base < sird_pkg::BASE_MIN || item.base > sird_pkg::BASE_MAX) begin
        ch.char_code = sird_pkg::CHAR_ERROR;
        ch.last      = 1'b1;
        ch.bad_base  = 1'b1;
        expected_chars.push_back(ch);
        return;
      end
      // Unsigned magnitude, so the most negative value maps to 2^31.
      rest = item.value[VW-1] ? ~item.value + VW'(1) : item.value;
      count = 0;
      do begin
        digits[count] = 4'(rest % item.base);
        rest = rest / item.base;
        count++;
      end while (rest != 0 && count < sird_pkg::MAX_DIGITS);
      ch.bad_base = 1'b0;
      if (item.value[VW-1]) begin
        ch.char_code = sird_pkg::CHAR_MINUS;
        ch.last      = 1'b0;
        expected_chars.push_back(ch);
      end
      for (int i = int'(count) - 1; i >= 0; i--) begin
        if (digits[i] < 4'd10) begin
          ch.char_code = sird_pkg::CHAR_ZERO + 8'(digits[i]);
        end else begin
          ch.char_code = sird_pkg::CHAR_A + 8'(digits[i]) - 8'd10;
        end
        ch.last = (i == 0);
        expected_chars.push_back(ch);
      end
    endfunction

    function void check_char(sird_pkg::out_t got);
      sird_pkg::out_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character transaction, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_code !== want.char_code || got.last !== want.last ||
          got.bad_base !== want.bad_base) begin
        mismatches++;
        $display("%0t: character mismatch: expected char_code=%h last=%b bad_base=%b",
                 $time, want.char_code, want.last, want.bad_base);
        $display("%0t:                     actual   char_code=%h last=%b bad_base=%b",
                 $time, got.char_code, got.last, got.bad_base);
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  sird_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  sird_pkg::out_t out_data_o;

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned quiet_cycles      = 0;

  digit_text_checker text_sb = new;

  signed_integer_to_radix_digits_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      text_sb.check_char(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic sird_pkg::in_t make_item(logic [VW-1:0] v, logic [BW-1:0] b);
    sird_pkg::in_t item;
    item.value = v;
    item.base  = b;
    return item;
  endfunction

  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: v = VW'(0) - VW'($urandom_range(1, 40));
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          default: v = '0;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [BW-1:0] pick_base();
    if ($urandom_range(0, 9) == 0) begin
      return BW'($urandom_range(0, 31));
    end
    return BW'($urandom_range(2, 16));
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input sird_pkg::in_t item);
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    text_sb.note_conversion(item);
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every predicted character has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (text_sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_random_phase(input int unsigned src_pct, input int unsigned snk_pct);
    sender_idle_pct   = src_pct;
    receiver_idle_pct = snk_pct;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      sender_gap();
      send_item(make_item(pick_value(), pick_base()));
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero, extremes, signs, every valid base and rejected bases.
    send_item(make_item(32'd0, 5'd10));
    send_item(make_item(32'd0, 5'd2));
    send_item(make_item(32'h8000_0000, 5'd2));
    send_item(make_item(32'h8000_0000, 5'd10));
    send_item(make_item(32'h8000_0000, 5'd16));
    send_item(make_item(32'h7FFF_FFFF, 5'd2));
    send_item(make_item(32'h7FFF_FFFF, 5'd16));
    send_item(make_item(32'hFFFF_FFFF, 5'd2));
    send_item(make_item(32'hFFFF_FFFF, 5'd16));
    send_item(make_item(32'd1, 5'd3));
    send_item(make_item(32'd12345, 5'd4));
    send_item(make_item(-32'sd35, 5'd5));
    send_item(make_item(32'd215, 5'd6));
    send_item(make_item(-32'sd48, 5'd7));
    send_item(make_item(32'd511, 5'd8));
    send_item(make_item(32'd728, 5'd9));
    send_item(make_item(-32'sd1000, 5'd11));
    send_item(make_item(32'd143, 5'd12));
    send_item(make_item(32'd2196, 5'd13));
    send_item(make_item(-32'sd195, 5'd14));
    send_item(make_item(32'd3374, 5'd15));
    send_item(make_item(-32'sd2748, 5'd16));
    send_item(make_item(32'd99, 5'd0));
    send_item(make_item(-32'sd5, 5'd1));
    send_item(make_item(32'h7FFF_FFFF, 5'd17));
    send_item(make_item(32'h8000_0000, 5'd31));
    wait_drained();

    run_random_phase(31, 79);
    run_random_phase(79, 31);
    run_random_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
